// ===== sv/qat_pkg.sv =====
`timescale 1ns / 1ps

package qat_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SLASH_W = 8;
	localparam int unsigned ARGS_W  = 8;

	// Saturation limits for the running counters
	localparam logic [SLASH_W-1:0] MAX_SLASH_RUN = 8'd255;
	localparam logic [ARGS_W-1:0]  MAX_ARGS      = 8'd255;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h5C;

	// Running tokenizer state
	typedef struct packed {
		logic               inside_arg;
		logic               inside_quote;
		logic               quote_pending;
		logic [SLASH_W-1:0] slash_run;
		logic [ARGS_W-1:0]  arg_counter;
	} qat_state_t;

	// One result transaction
	typedef struct packed {
		logic [SLASH_W-1:0] out_slashes;
		logic               char_valid;
		logic [BYTE_W-1:0]  out_byte;
		logic               end_arg;
		logic               end_line;
		logic [ARGS_W-1:0]  arg_total;
	} qat_result_t;

	// Argument separator outside quotes
	function automatic logic is_sep(input logic [BYTE_W-1:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
	endfunction

endpackage

// ===== sv/qat_step.sv =====
`timescale 1ns / 1ps

module qat_step (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [qat_pkg::BYTE_W-1:0] byte_s1,
	output logic                       emit,
	output qat_pkg::qat_result_t       result,
	output qat_pkg::qat_state_t        state_q
);
	import qat_pkg::*;

	qat_state_t state_d;

	// Next state and result for the byte in the input register
	always_comb begin
		logic handled;
		logic silent;
		logic [SLASH_W-1:0] slashes;
		logic cv;
		logic [BYTE_W-1:0] ob;
		logic ea;
		logic el;

		state_d = state_q;
		handled = 1'b0;
		silent  = 1'b0;
		slashes = '0;
		cv      = 1'b0;
		ob      = '0;
		ea      = 1'b0;
		el      = 1'b0;

		if (byte_s1 == CH_NUL) begin
			// line end: flush held backslashes, close argument, clear all
			if (state_q.inside_arg) begin
				slashes = state_q.slash_run;
				ea      = 1'b1;
			end
			el      = 1'b1;
			state_d = '0;
		end else begin
			// second quote of a doubled quote pair
			if (state_q.quote_pending) begin
				state_d.quote_pending = 1'b0;
				if (byte_s1 == CH_QUOTE) begin
					cv      = 1'b1;
					ob      = byte_s1;
					handled = 1'b1;
				end
			end

			// separators between arguments are dropped; anything else opens one
			if (!handled && !state_q.inside_arg) begin
				if (is_sep(byte_s1)) begin
					silent = 1'b1;
				end else begin
					state_d.inside_arg = 1'b1;
					if (state_q.arg_counter < MAX_ARGS)
						state_d.arg_counter = state_q.arg_counter + 1'b1;
				end
			end

			if (!handled && !silent) begin
				if (byte_s1 == CH_SLASH) begin
					if (state_q.slash_run < MAX_SLASH_RUN)
						state_d.slash_run = state_q.slash_run + 1'b1;
					silent = 1'b1;
				end else begin
					if (byte_s1 == CH_QUOTE) begin
						slashes = state_q.slash_run >> 1;
						if (state_q.slash_run[0]) begin
							cv = 1'b1;
							ob = byte_s1;
						end else if (state_q.inside_quote) begin
							state_d.inside_quote  = 1'b0;
							state_d.quote_pending = 1'b1;
						end else begin
							state_d.inside_quote = 1'b1;
						end
					end else if (is_sep(byte_s1) && !state_q.inside_quote) begin
						slashes            = state_q.slash_run;
						ea                 = 1'b1;
						state_d.inside_arg = 1'b0;
					end else begin
						slashes = state_q.slash_run;
						cv      = 1'b1;
						ob      = byte_s1;
					end
					state_d.slash_run = '0;
				end
			end
		end

		emit = el || (!silent && ((slashes != '0) || cv || ea));
		result.out_slashes = slashes;
		result.char_valid  = cv;
		result.out_byte    = ob;
		result.end_arg     = ea;
		result.end_line    = el;
		result.arg_total   = (byte_s1 == CH_NUL) ? state_q.arg_counter : state_d.arg_counter;
	end

	// State register, updated once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/qat_out_reg.sv =====
`timescale 1ns / 1ps

module qat_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  qat_pkg::qat_result_t result,
	input  logic                 out_ready,
	output logic                 out_valid,
	output qat_pkg::qat_result_t held
);
	import qat_pkg::*;

	logic        valid_q;
	qat_result_t data_q;

	// Valid flag: set on load, cleared when the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign held      = data_q;

endmodule

// ===== sv/quoted_argument_tokenizer_top.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake           | Payload
// input    | in_valid/in_ready   | in_byte
// output   | out_valid/out_ready | out_slashes, char_valid, out_byte, end_arg,
//          |                     | end_line, arg_total
//
// One byte per clock sustained while the output is not stalled. A byte is held in the
// input register, decoded against the running state, and its result (if any) is
// loaded into the output register when the byte is consumed.
// Reset (arst_n low) clears the state, the argument count and both valid flags.
// A stalled output holds the input register; in_ready drops only while the
// input register is full and its result cannot be written.

module quoted_argument_tokenizer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [qat_pkg::BYTE_W-1:0]   in_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [qat_pkg::SLASH_W-1:0]  out_slashes,
	output logic                         char_valid,
	output logic [qat_pkg::BYTE_W-1:0]   out_byte,
	output logic                         end_arg,
	output logic                         end_line,
	output logic [qat_pkg::ARGS_W-1:0]   arg_total
);
	import qat_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              advance;
	logic              emit;
	qat_result_t       result;
	qat_result_t       held;
	qat_state_t        state_q;

	// Pipeline control
	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	qat_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.emit    (emit),
		.result  (result),
		.state_q (state_q)
	);

	qat_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.held      (held)
	);

	assign out_slashes = held.out_slashes;
	assign char_valid  = held.char_valid;
	assign out_byte    = held.out_byte;
	assign end_arg     = held.end_arg;
	assign end_line    = held.end_line;
	assign arg_total   = held.arg_total;

`ifndef SYNTHESIS
	// A consumed line end leaves the state fully cleared
	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 == CH_NUL |=> state_q == '0)
		else $error("state not cleared after line end");

	// Input side stalls only behind a full input register and a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled without cause");

	// A line end result never carries an argument byte
	a_end_line_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_line |-> !char_valid && out_byte == '0)
		else $error("line end carries a byte");

	// An argument can only end after one has been counted
	a_end_arg_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_arg |-> arg_total != '0)
		else $error("argument ended with zero count");

	// Held backslashes exist only inside an argument
	a_run_in_arg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.slash_run != '0 |-> state_q.inside_arg)
		else $error("backslash run outside argument");
`endif

endmodule
